// ----- rtl/core/packed_sample_unpacker_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the packed sample unpacker
// Concurrent assertion helpers. They compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef PACKED_SAMPLE_UNPACKER_UNIT_ASSERT_SVH
`define PACKED_SAMPLE_UNPACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition must never hold.
`define PSU_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("psu assertion failed: condition must never hold");
// The consequent holds in the same cycle as the antecedent.
`define PSU_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psu assertion failed: implication");
// The consequent holds in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psu assertion failed: next-cycle implication");
`else
`define PSU_ASSERT_NEVER(name, clk, rst, cond)
`define PSU_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define PSU_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/psu_pkg.sv -----
// ---------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the packed sample unpacker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psu_pkg;

   localparam int WORD_BITS    = 32;
   localparam int COUNTER_BITS = 19;
   localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

   localparam int SPW_BITS   = 13;
   localparam int CC_BITS    = 7;
   localparam int SLOT_BITS  = 7;
   localparam int CSR_W      = 13;
   localparam int GROUP_BITS = 16;

   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 6;
   localparam int IDX_W    = 12;
   localparam int GCH_W    = 14;

   localparam logic [CHAN_W-1:0] CHAN_SAT = '1;
   localparam logic [IDX_W-1:0]  IDX_SAT  = '1;

   localparam int SAMPLE_GROUP = 3;
   localparam int CHAN_GROUP   = 8;
   localparam int SLOT_STRIDE  = 100;

   localparam logic [SPW_BITS-1:0]  SPW_RESET  = 13'd3000;
   localparam logic [CC_BITS-1:0]   CC_RESET   = 7'd64;
   localparam logic [SLOT_BITS-1:0] SLOT_RESET = 7'd7;

   // Shared divider sizes.
   localparam int DIV_BITS  = COUNTER_BITS;
   localparam int DIVR_BITS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

   typedef enum logic [1:0] {
      CSR_SPW        = 2'd0,
      CSR_CHAN_COUNT = 2'd1,
      CSR_SLOT       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRP_GO,
      ST_GRP_WAIT,
      ST_IDX_GO,
      ST_IDX_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  dividend;
      logic [DIVR_BITS-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_BITS-1:0]  quotient;
      logic [DIVR_BITS-1:0] remainder;
   } div_stat_type;

endpackage

// ----- rtl/core/packed_sample_unpacker_unit.sv -----
// An accepted word's sample words are registered onto rsp_ from the ST_EMIT state.
// A 32-bit word carries two or three samples, and the single sample extraction path issues one
//   sample per cycle while rsp_ is not stalled; the next word is only taken once back in idle.
// The first word after a samples_per_waveform write without first_word set waits
//   while the shared 19-bit divider re-derives the channel and index counters.
// Reset is synchronous and active high; it restores the register defaults and empties the core.
// ---------------------------------------------------------------------------
// packed_sample_unpacker_unit
// Unpacks bit-packed ADC samples from 32-bit payload words and tags each one
// with its board channel, waveform position and global channel id.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packed_sample_unpacker_unit_assert.svh"

module packed_sample_unpacker_unit
   import psu_pkg::*;
#(
   parameter int SAMPLE_BITS  = 12,
   parameter int MAX_SAMPLES  = 4096,
   parameter int MAX_CHANNELS = 64
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_data_word,
   input  logic                 req_first_word,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]  rsp_sample,
   output logic [CHAN_W-1:0]    rsp_channel,
   output logic [IDX_W-1:0]     rsp_sample_index,
   output logic [GCH_W-1:0]     rsp_global_channel,
   output logic                 rsp_in_range,
   output logic                 rsp_last_of_word,

   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // The bit store holds the leftover bits of the previous word followed by
   // the whole new word. Samples are peeled off its low end.
   localparam int STORE_W = WORD_BITS + SAMPLE_BITS;
   localparam int CNT_W   = $clog2(STORE_W);
   localparam int RES_W   = $clog2(SAMPLE_BITS);
   localparam int IB_W    = SPW_BITS + 1;
   localparam int CHF_W   = GROUP_BITS + 3;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [SPW_BITS-1:0]  spw_ff, spw_in;
   logic [CC_BITS-1:0]   cc_ff, cc_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 csr_spw_wr;

   assign csr_spw_wr = csr_write_en && (csr_index == CSR_SPW);

   always_comb begin
      spw_in  = spw_ff;
      cc_in   = cc_ff;
      slot_in = slot_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SPW:        spw_in  = csr_wdata[SPW_BITS-1:0];
            CSR_CHAN_COUNT: cc_in   = csr_wdata[CC_BITS-1:0];
            CSR_SLOT:       slot_in = csr_wdata[SLOT_BITS-1:0];
            default:        spw_in  = spw_ff;
         endcase
      end
   end

   // A zero waveform length behaves as a length of one.
   logic [SPW_BITS-1:0]  spw_eff;
   logic [DIVR_BITS-1:0] grp_div;

   assign spw_eff = (spw_ff == '0) ? SPW_BITS'(1) : spw_ff;
   assign grp_div = DIVR_BITS'(spw_eff) << 3;

   // ------------------------------------------------------------------
   // Sequencer state and running sample position
   // ------------------------------------------------------------------
   // The sample number S is tracked together with the pieces derived from
   // it, so that each sample only needs increments and compares:
   //   p3    = S mod 3,   q8 = (S / 3) mod 8
   //   remg  = S mod (8 * spw),   grp = S / (8 * spw)
   //   ibase = (3 * (S / 24)) mod spw
   // After a new waveform length is written these are rebuilt from S by
   // the shared divider before the next word is cut up.
   state_type               state_ff, state_in;
   logic                    dirty_ff, dirty_in;
   logic [COUNTER_BITS-1:0] s_ff, s_in;
   logic [1:0]              p3_ff, p3_in;
   logic [2:0]              q8_ff, q8_in;
   logic [DIVR_BITS-1:0]    remg_ff, remg_in;
   logic [GROUP_BITS-1:0]   grp_ff, grp_in;
   logic [SPW_BITS-1:0]     ibase_ff, ibase_in;

   logic [STORE_W-1:0]      store_ff, store_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SAMPLE_BITS-1:0]  resid_ff, resid_in;
   logic [RES_W-1:0]        rcount_ff, rcount_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;
   logic [CHAN_W-1:0]       rsp_channel_ff, rsp_channel_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [GCH_W-1:0]        rsp_gch_ff, rsp_gch_in;
   logic                    rsp_range_ff, rsp_range_in;
   logic                    rsp_last_ff, rsp_last_in;

   div_ctrl_type            div_ctrl;
   div_stat_type            div_stat;

   psu_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // ------------------------------------------------------------------
   // Per-sample derived values
   // ------------------------------------------------------------------
   logic [CHF_W-1:0]        chan_full;
   logic [IB_W-1:0]         idx_full;
   logic [STORE_W-1:0]      low_bits;
   logic [STORE_W-1:0]      store_shift;
   logic [CNT_W-1:0]        count_next;
   logic [4:0]              s_mod24;
   logic [COUNTER_BITS-1:0] idx_num;
   logic [IB_W-1:0]         ib_step;
   logic                    load_en;

   // Channel is q8 + 8 * grp, which is simply their concatenation.
   assign chan_full   = {grp_ff, q8_ff};
   assign idx_full    = IB_W'(ibase_ff) + IB_W'(p3_ff);
   assign low_bits    = store_ff & STORE_W'((1 << SAMPLE_BITS) - 1);
   assign store_shift = store_ff >> SAMPLE_BITS;
   assign count_next  = count_ff - CNT_W'(SAMPLE_BITS);

   // 3 * (S / 24) equals (S - S mod 24) / 8, and S mod 24 is 3 * q8 + p3.
   assign s_mod24 = {q8_ff, 1'b0} + 5'(q8_ff) + 5'(p3_ff);
   assign idx_num = (s_ff - COUNTER_BITS'(s_mod24)) >> 3;

   // Advance the waveform base by three samples modulo the waveform length.
   // Three conditional subtractions cover lengths of one and two as well.
   always_comb begin
      ib_step = IB_W'(ibase_ff) + IB_W'(SAMPLE_GROUP);
      for (int k = 0; k < SAMPLE_GROUP; k++) begin
         if (ib_step >= IB_W'(spw_eff)) begin
            ib_step = ib_step - IB_W'(spw_eff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Next state and datapath
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      dirty_in  = dirty_ff | csr_spw_wr;
      s_in      = s_ff;
      p3_in     = p3_ff;
      q8_in     = q8_ff;
      remg_in   = remg_ff;
      grp_in    = grp_ff;
      ibase_in  = ibase_ff;
      store_in  = store_ff;
      count_in  = count_ff;
      resid_in  = resid_ff;
      rcount_in = rcount_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_gch_in     = rsp_gch_ff;
      rsp_range_in   = rsp_range_ff;
      rsp_last_in    = rsp_last_ff;

      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = s_ff;
      div_ctrl.divisor  = grp_div;

      load_en   = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_first_word) begin
                  // A new event starts: drop leftover bits and restart S.
                  s_in      = '0;
                  p3_in     = '0;
                  q8_in     = '0;
                  remg_in   = '0;
                  grp_in    = '0;
                  ibase_in  = '0;
                  dirty_in  = csr_spw_wr;
                  store_in  = STORE_W'(req_data_word);
                  count_in  = CNT_W'(WORD_BITS);
                  state_in  = ST_EMIT;
               end else begin
                  store_in = STORE_W'(resid_ff) | (STORE_W'(req_data_word) << rcount_ff);
                  count_in = CNT_W'(rcount_ff) + CNT_W'(WORD_BITS);
                  state_in = dirty_ff ? ST_GRP_GO : ST_EMIT;
               end
            end
         end

         ST_GRP_GO: begin
            div_ctrl.start = 1'b1;
            state_in       = ST_GRP_WAIT;
         end

         ST_GRP_WAIT: begin
            if (div_stat.done) begin
               grp_in   = div_stat.quotient[GROUP_BITS-1:0];
               remg_in  = div_stat.remainder;
               state_in = ST_IDX_GO;
            end
         end

         ST_IDX_GO: begin
            div_ctrl.start    = 1'b1;
            div_ctrl.dividend = idx_num;
            div_ctrl.divisor  = DIVR_BITS'(spw_eff);
            state_in          = ST_IDX_WAIT;
         end

         ST_IDX_WAIT: begin
            if (div_stat.done) begin
               ibase_in = div_stat.remainder[SPW_BITS-1:0];
               dirty_in = csr_spw_wr;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_en       = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = low_bits[SAMPLE_W-1:0];

               rsp_channel_in = (chan_full > CHF_W'(CHAN_SAT)) ? CHAN_SAT
                                                               : chan_full[CHAN_W-1:0];
               rsp_index_in   = (idx_full > IB_W'(IDX_SAT)) ? IDX_SAT : idx_full[IDX_W-1:0];
               rsp_gch_in     = GCH_W'(slot_ff) * GCH_W'(SLOT_STRIDE) + GCH_W'(rsp_channel_in);
               // The range test looks at the values before saturation.
               rsp_range_in   = (chan_full < CHF_W'(cc_ff)) &&
                                (32'(chan_full) < MAX_CHANNELS) &&
                                (idx_full < IB_W'(spw_eff)) &&
                                (32'(idx_full) < MAX_SAMPLES);
               rsp_last_in    = count_next < CNT_W'(SAMPLE_BITS);

               store_in = store_shift;
               count_in = count_next;

               // S stops at its top value; the derived counters stop with it.
               if (s_ff != COUNTER_MAX) begin
                  s_in = s_ff + 1'b1;
                  if (p3_ff == 2'(SAMPLE_GROUP - 1)) begin
                     p3_in = '0;
                     q8_in = q8_ff + 1'b1;
                     if (q8_ff == 3'(CHAN_GROUP - 1)) begin
                        ibase_in = ib_step[SPW_BITS-1:0];
                     end
                  end else begin
                     p3_in = p3_ff + 1'b1;
                  end
                  if ((DIVR_BITS + 1)'(remg_ff) + 1'b1 == (DIVR_BITS + 1)'(grp_div)) begin
                     remg_in = '0;
                     grp_in  = grp_ff + 1'b1;
                  end else begin
                     remg_in = remg_ff + 1'b1;
                  end
               end

               if (rsp_last_in) begin
                  resid_in  = store_shift[SAMPLE_BITS-1:0];
                  rcount_in = count_next[RES_W-1:0];
                  state_in  = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         spw_ff       <= SPW_RESET;
         cc_ff        <= CC_RESET;
         slot_ff      <= SLOT_RESET;
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b0;
         s_ff         <= '0;
         p3_ff        <= '0;
         q8_ff        <= '0;
         remg_ff      <= '0;
         grp_ff       <= '0;
         ibase_ff     <= '0;
         resid_ff     <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spw_ff       <= spw_in;
         cc_ff        <= cc_in;
         slot_ff      <= slot_in;
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         s_ff         <= s_in;
         p3_ff        <= p3_in;
         q8_ff        <= q8_in;
         remg_ff      <= remg_in;
         grp_ff       <= grp_in;
         ibase_ff     <= ibase_in;
         resid_ff     <= resid_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff       <= store_in;
      count_ff       <= count_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_gch_ff     <= rsp_gch_in;
      rsp_range_ff   <= rsp_range_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_sample_index   = rsp_index_ff;
   assign rsp_global_channel = rsp_gch_ff;
   assign rsp_in_range       = rsp_range_ff;
   assign rsp_last_of_word   = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Leftover bits never amount to a whole sample.
   `PSU_ASSERT_NEVER(a_resid_short, clock, reset, 32'(rcount_ff) >= SAMPLE_BITS)
   // The last sample of a word hands control back to the idle state.
   `PSU_ASSERT_NEXT(a_last_to_idle, clock, reset, load_en && rsp_last_in, state_ff == ST_IDLE)
   // S only moves up, except when a new event starts.
   `PSU_ASSERT_NEXT(a_s_monotone, clock, reset, !(req_valid && req_ready && req_first_word), s_ff >= $past(s_ff))

endmodule

// ----- rtl/core/psu_div.sv -----
// ---------------------------------------------------------------------------
// psu_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psu_div
   import psu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIVR_BITS-1:0] rem_ff, rem_in;
   logic [DIVR_BITS-1:0] dvs_ff, dvs_in;

   logic [DIVR_BITS:0]   trial;
   logic [DIVR_BITS+1:0] diff;
   logic                 borrow;

   assign trial  = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff   = {1'b0, trial} - {2'b00, dvs_ff};
   assign borrow = diff[DIVR_BITS+1];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_BITS);
         quo_in  = ctrl.dividend;
         rem_in  = '0;
         dvs_in  = ctrl.divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            quo_in = {quo_ff[DIV_BITS-2:0], ~borrow};
            rem_in = borrow ? trial[DIVR_BITS-1:0] : diff[DIVR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done      = busy_ff && (cnt_ff == '0);
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

// ----- tb/tb_packed_sample_unpacker_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_packed_sample_unpacker_unit
// Self-checking bench for the packed sample unpacker. Payload words go in on
// the req_ channel, and every sample word on the rsp_ channel is compared
// field by field against a behavioral unpacker kept inside the bench.
// ---------------------------------------------------------------------------

module tb_packed_sample_unpacker_unit
   import psu_pkg::*;
();

   // Limits the block is built with; they are passed to the instance below.
   localparam int CHANNEL_CAP = 64;
   localparam int INDEX_CAP   = 4096;

   // Time limit for a full run, even with the longest stalls on both sides.
   localparam int WATCHDOG_NS = 2_000_000;

   // Mismatch lines beyond this count are counted but not printed.
   localparam int PRINT_CAP = 100;

   // One tagged sample, exactly as the block presents it on rsp_.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   channel;
      logic [IDX_W-1:0]    sample_index;
      logic [GCH_W-1:0]    global_channel;
      logic                in_range;
      logic                last_of_word;
   } unpacked_sample_type;

   // One row of the directed table. When settle is set, the bench drains the
   // block and writes all three registers before the row's word is sent. When
   // known is set, the first sample of the word is checked against the typed
   // h_ columns instead of the bench's own prediction.
   typedef struct packed {
      logic                 settle;
      logic [CSR_W-1:0]     spw;
      logic [CSR_W-1:0]     cc;
      logic [CSR_W-1:0]     slot;
      logic [WORD_BITS-1:0] word;
      logic                 first;
      logic                 known;
      logic [SAMPLE_W-1:0]  h_sample;
      logic [CHAN_W-1:0]    h_chan;
      logic [IDX_W-1:0]     h_idx;
      logic [GCH_W-1:0]     h_gch;
      logic                 h_in;
      logic                 h_last;
   } stim_row_type;

   // Clock, reset and every block input start at a known value.
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [WORD_BITS-1:0] req_data_word  = '0;
   logic                 req_first_word = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_sample;
   logic [CHAN_W-1:0]    rsp_channel;
   logic [IDX_W-1:0]     rsp_sample_index;
   logic [GCH_W-1:0]     rsp_global_channel;
   logic                 rsp_in_range;
   logic                 rsp_last_of_word;
   logic                 csr_write_en   = 1'b0;
   logic [1:0]           csr_index      = CSR_SPW;
   logic [CSR_W-1:0]     csr_wdata      = '0;

   // Shadow copy of the block's registers and unpacking state.
   logic [SPW_BITS-1:0]     waveform_len   = SPW_RESET;
   logic [CC_BITS-1:0]      channel_limit  = CC_RESET;
   logic [SLOT_BITS-1:0]    slot_number    = SLOT_RESET;
   logic [SAMPLE_W-1:0]     leftover_bits  = '0;
   int                      leftover_count = 0;
   logic [COUNTER_BITS-1:0] sample_number  = '0;

   // Samples predicted for accepted words, oldest first.
   unpacked_sample_type pending_samples [$];

   int mismatch_count = 0;

   // When clear, neither side inserts idle cycles, giving back-to-back stretches.
   bit pace_idle = 1'b1;

   // The directed table. Reset defaults are 3000 samples per waveform,
   // 64 channels and slot 7, so a first word tags its first sample with
   // channel 0, index 0 and global channel 700.
   stim_row_type directed_rows [0:23] = '{
      // Reset settings: all-ones, all-zeros and alternating patterns walk the
      // leftover bits through a full three-word cycle.
      '{0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 12'hFFF, 0, 0, 700, 1, 0},
      '{0, 0, 0, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'hA5A5_A5A5, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h1234_5678, 1, 1, 12'h678, 0, 0, 700, 1, 0},
      '{0, 0, 0, 0, 32'h8000_0001, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'hDEAD_BEEF, 0, 0, 0, 0, 0, 0, 0, 0},
      // A zero waveform length is handled as a length of one.
      '{1, 0, 1, 0, 32'h0000_0FFF, 1, 1, 12'hFFF, 0, 0, 0, 1, 0},
      '{0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h1357_9BDF, 0, 0, 0, 0, 0, 0, 0, 0},
      // No channels configured: every sample is flagged out of range.
      '{1, 1, 0, 99, 32'h0000_0000, 1, 1, 12'h000, 0, 0, 9900, 0, 0},
      '{0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h0F0F_0F0F, 0, 0, 0, 0, 0, 0, 0, 0},
      // Largest slot number that fits the register.
      '{1, 24, 64, 127, 32'hFFF0_0FFF, 1, 1, 12'hFFF, 0, 0, 12700, 1, 0},
      '{0, 0, 0, 0, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0},
      // Registers rewritten in the middle of an event, without a first word,
      // so the block has to re-derive its channel and index counters.
      '{1, 5, 3, 1, 32'h7777_7777, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h8888_8888, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 8191, 127, 99, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h0000_0FFF, 1, 1, 12'hFFF, 0, 0, 9900, 1, 0},
      '{0, 0, 0, 0, 32'hFFFF_F000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 3, 8, 10, 32'h0F0F_F0F0, 1, 1, 12'h0F0, 0, 0, 1000, 1, 0},
      '{0, 0, 0, 0, 32'hC3C3_3C3C, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h6996_9669, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   packed_sample_unpacker_unit #(
      .SAMPLE_BITS  (SAMPLE_W),
      .MAX_SAMPLES  (INDEX_CAP),
      .MAX_CHANNELS (CHANNEL_CAP)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_first_word     (req_first_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample         (rsp_sample),
      .rsp_channel        (rsp_channel),
      .rsp_sample_index   (rsp_sample_index),
      .rsp_global_channel (rsp_global_channel),
      .rsp_in_range       (rsp_in_range),
      .rsp_last_of_word   (rsp_last_of_word),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tags one sample with the running sample number as it stands now. The
   // channel steps every three samples through a group of eight, and a new
   // group of eight channels starts after eight full waveforms. Both fields
   // saturate on output, but the range flag looks at the unsaturated values.
   function automatic unpacked_sample_type tag_sample(input logic [SAMPLE_W-1:0] value,
                                                     input logic last);
      unpacked_sample_type entry;
      int unsigned         s;
      int unsigned         spw;
      int unsigned         chan;
      int unsigned         idx;
      int unsigned         gch;
      s    = sample_number;
      spw  = (waveform_len == '0) ? 1 : waveform_len;
      chan = (s / SAMPLE_GROUP) % CHAN_GROUP + CHAN_GROUP * (s / (CHAN_GROUP * spw));
      idx  = s % SAMPLE_GROUP + (SAMPLE_GROUP * (s / (SAMPLE_GROUP * CHAN_GROUP))) % spw;
      entry.sample         = value;
      entry.channel        = (chan > CHAN_SAT) ? CHAN_SAT : chan[CHAN_W-1:0];
      entry.sample_index   = (idx > IDX_SAT) ? IDX_SAT : idx[IDX_W-1:0];
      gch                  = slot_number * SLOT_STRIDE + entry.channel;
      entry.global_channel = gch[GCH_W-1:0];
      entry.in_range       = chan < channel_limit && chan < CHANNEL_CAP &&
                             idx < spw && idx < INDEX_CAP;
      entry.last_of_word   = last;
      return entry;
   endfunction

   // Splits one accepted word into samples, least significant bits first,
   // prefixed by whatever bits the previous word left behind. Queues the
   // tagged samples and returns how many there were.
   function automatic int unpack_word(input logic [WORD_BITS-1:0] word, input logic first);
      logic [WORD_BITS+SAMPLE_W-1:0] store;
      int                            held;
      int                            produced;
      if (first) begin
         leftover_bits  = '0;
         leftover_count = 0;
         sample_number  = '0;
      end
      store    = ({{SAMPLE_W{1'b0}}, word} << leftover_count) | leftover_bits;
      held     = leftover_count + WORD_BITS;
      produced = 0;
      while (held >= SAMPLE_W) begin
         held -= SAMPLE_W;
         pending_samples = {pending_samples,
                            tag_sample(store[SAMPLE_W-1:0], held < SAMPLE_W)};
         store >>= SAMPLE_W;
         // The counter sticks at its top; later samples reuse that number.
         if (sample_number != COUNTER_MAX) begin
            sample_number++;
         end
         produced++;
      end
      leftover_bits  = store[SAMPLE_W-1:0];
      leftover_count = held;
      return produced;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
      end
   endtask

   // Offers one word and returns at the edge that accepts it. Valid is only
   // dropped when an idle gap is drawn, so back-to-back words keep it high.
   task automatic offer_word(input logic [WORD_BITS-1:0] word, input logic first,
                             output int produced);
      int gap;
      gap = pace_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_first_word <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = unpack_word(word, first);
   endtask

   // Stops sending and waits for every predicted sample to come back. Every
   // word yields at least two samples, so an empty queue means the block is
   // idle; the task still waits on its output stage before it returns.
   task automatic wait_for_all_samples();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges. Only called while idle.
   task automatic apply_settings(input logic [CSR_W-1:0] spw_word,
                                 input logic [CSR_W-1:0] cc_word,
                                 input logic [CSR_W-1:0] slot_word);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SPW;
      csr_wdata    <= spw_word;
      @(posedge clock);
      csr_index    <= CSR_CHAN_COUNT;
      csr_wdata    <= cc_word;
      @(posedge clock);
      csr_index    <= CSR_SLOT;
      csr_wdata    <= slot_word;
      @(posedge clock);
      csr_write_en  <= 1'b0;
      waveform_len  = spw_word;
      channel_limit = cc_word[CC_BITS-1:0];
      slot_number   = slot_word[SLOT_BITS-1:0];
   endtask

   // Result side: draws a stall before each sample word, then holds ready
   // high until one is taken.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pace_idle ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Every accepted sample word is matched against the oldest prediction.
   always @(posedge clock) begin
      unpacked_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected sample word, sample", rsp_sample, 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample)
               report_mismatch("sample", rsp_sample, want.sample);
            if (rsp_channel !== want.channel)
               report_mismatch("channel", rsp_channel, want.channel);
            if (rsp_sample_index !== want.sample_index)
               report_mismatch("sample_index", rsp_sample_index, want.sample_index);
            if (rsp_global_channel !== want.global_channel)
               report_mismatch("global_channel", rsp_global_channel, want.global_channel);
            if (rsp_in_range !== want.in_range)
               report_mismatch("in_range", rsp_in_range, want.in_range);
            if (rsp_last_of_word !== want.last_of_word)
               report_mismatch("last_of_word", rsp_last_of_word, want.last_of_word);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(WATCHDOG_NS);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      stim_row_type        row;
      unpacked_sample_type head;
      int                  produced;
      int                  sent;
      int                  len;
      logic                first;
      logic [CSR_W-1:0]    spw_word;
      logic [CSR_W-1:0]    cc_word;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.settle) begin
            wait_for_all_samples();
            apply_settings(row.spw, row.cc, row.slot);
         end
         offer_word(row.word, row.first, produced);
         if (row.known) begin
            head.sample         = row.h_sample;
            head.channel        = row.h_chan;
            head.sample_index   = row.h_idx;
            head.global_channel = row.h_gch;
            head.in_range       = row.h_in;
            head.last_of_word   = row.h_last;
            pending_samples[pending_samples.size() - produced] = head;
         end
      end

      // Long event: back to back on both sides with a waveform length of one,
      // so the channel runs past six bits after a few dozen samples. The
      // channel and slot writes carry junk in the bits above the seven the
      // registers keep.
      wait_for_all_samples();
      apply_settings(13'd1, 13'h1F7F, 13'h1E63);
      pace_idle = 1'b0;
      offer_word($urandom, 1'b1, produced);
      repeat (25) offer_word($urandom, 1'b0, produced);

      // Random part: ten phases, each with fresh register settings, made of
      // short events that mostly start with a first word. Some events run
      // without idle cycles, and the sender now and then waits for the block
      // to empty in the middle of an event.
      for (int phase = 0; phase < 10; phase++) begin
         wait_for_all_samples();
         case ($urandom_range(0, 5))
            0: spw_word = '0;
            1: spw_word = CSR_W'($urandom_range(1, 6));
            2: spw_word = CSR_W'(SAMPLE_GROUP * $urandom_range(1, 16));
            3: spw_word = CSR_W'($urandom_range(1, 64));
            4: spw_word = SPW_RESET;
            default: spw_word = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
         endcase
         cc_word = CSR_W'($urandom_range(0, 1) ? $urandom_range(0, 16)
                                               : $urandom_range(0, 127));
         apply_settings(spw_word, cc_word, CSR_W'($urandom_range(0, 127)));
         sent = 0;
         while (sent < 15) begin
            len       = $urandom_range(1, 12);
            pace_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++) begin
               first = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
               offer_word($urandom, first, produced);
               sent++;
               if ($urandom_range(0, 29) == 0) begin
                  wait_for_all_samples();
               end
            end
         end
      end

      pace_idle = 1'b1;
      wait_for_all_samples();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
